// ===== design/zpg_pkg.sv =====
// ----------------------------------------------------------------------------
// zpg_pkg: shared types and constants of the zone plate generator
// Register indexes, reset values, fixed-point constants and the structs that
// travel between the raster, phase and cosine ROM stages.
// ----------------------------------------------------------------------------
`default_nettype none

package zpg_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOG2_SIZE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTE_OUTPUT = 2'd1;

   localparam logic [CSR_DATA_WIDTH-1:0] LOG2_SIZE_RESET   = 4'd8;
   localparam logic                      BYTE_OUTPUT_RESET = 1'b1;

   localparam int PIXEL_WIDTH = 16;
   localparam int MAG_WIDTH   = 15;
   localparam int BYTE_WIDTH  = 8;

   // Q30 fixed point
   localparam longint unsigned Q30_ONE     = 64'h0000_0000_4000_0000;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic end_of_line;
      logic end_of_frame;
   } raster_flags_type;

   // One ROM word: cosine magnitude and the byte codes for +mag and -mag
   typedef struct packed {
      logic [MAG_WIDTH-1:0]  mag;
      logic [BYTE_WIDTH-1:0] byte_pos;
      logic [BYTE_WIDTH-1:0] byte_neg;
   } cos_word_type;

endpackage

`default_nettype wire

// ===== design/zpg_raster.sv =====
// ----------------------------------------------------------------------------
// zpg_raster: raster position counters
// Tracks the next pixel, applies restart, raises the end of line and end of
// frame flags and registers the absolute centred coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module zpg_raster #(
   parameter int MAX_LOG2_SIZE = 12
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 load,
   input  wire logic                                 accept,
   input  wire logic                                 restart,
   input  wire logic [$clog2(MAX_LOG2_SIZE+1)-1:0]   lg,
   output logic      [MAX_LOG2_SIZE-1:0]             abs_col,
   output logic      [MAX_LOG2_SIZE-1:0]             abs_row,
   output zpg_pkg::raster_flags_type                 flags
);

   localparam int W    = MAX_LOG2_SIZE;
   localparam int LG_W = $clog2(MAX_LOG2_SIZE+1);

   logic [W-1:0] col_ff, col_in;
   logic [W-1:0] row_ff, row_in;
   logic [W-1:0] abs_col_ff, abs_col_in;
   logic [W-1:0] abs_row_ff, abs_row_in;
   zpg_pkg::raster_flags_type flags_ff, flags_in;

   logic [W-1:0]   col_use, row_use;
   logic [W-1:0]   half_size;
   logic [W:0]     size_full;
   logic [W-1:0]   last_pos;
   logic signed [W:0] di, dj;

   always_comb begin
      col_use   = restart ? '0 : col_ff;
      row_use   = restart ? '0 : row_ff;
      half_size = W'(1) << (lg - LG_W'(1));
      size_full = (W+1)'(1) << lg;
      last_pos  = W'(size_full - (W+1)'(1));

      di = signed'({1'b0, col_use}) - signed'({1'b0, half_size});
      dj = signed'({1'b0, row_use}) - signed'({1'b0, half_size});
      abs_col_in = di[W] ? W'(-di) : W'(di);
      abs_row_in = dj[W] ? W'(-dj) : W'(dj);

      flags_in.end_of_line  = col_use >= last_pos;
      flags_in.end_of_frame = flags_in.end_of_line && (row_use >= last_pos);

      // wrap at end of line, and to the top left at end of frame
      if (flags_in.end_of_line) begin
         col_in = '0;
         row_in = flags_in.end_of_frame ? '0 : row_use + W'(1);
      end else begin
         col_in = col_use + W'(1);
         row_in = row_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         abs_col_ff <= abs_col_in;
         abs_row_ff <= abs_row_in;
         flags_ff   <= flags_in;
      end
   end

   assign abs_col = abs_col_ff;
   assign abs_row = abs_row_ff;
   assign flags   = flags_ff;

endmodule

`default_nettype wire

// ===== design/zpg_phase.sv =====
// ----------------------------------------------------------------------------
// zpg_phase: phase and ROM address stages
// Squares the centred coordinates, reduces the phase modulo twice the side,
// scales it to a cosine index and folds the index into an octant address.
// ----------------------------------------------------------------------------
`default_nettype none

module zpg_phase #(
   parameter int MAX_LOG2_SIZE = 12,
   parameter int TABLE_BITS    = 10
) (
   input  wire logic                                 clock,
   input  wire logic                                 load,
   input  wire logic [MAX_LOG2_SIZE-1:0]             abs_col,
   input  wire logic [MAX_LOG2_SIZE-1:0]             abs_row,
   input  wire logic [$clog2(MAX_LOG2_SIZE+1)-1:0]   lg,
   input  zpg_pkg::raster_flags_type                 flags_i,
   output logic      [TABLE_BITS-2:0]                rom_addr,
   output logic                                      negate,
   output zpg_pkg::raster_flags_type                 flags_o
);

   localparam int W       = MAX_LOG2_SIZE;
   localparam int PW      = MAX_LOG2_SIZE + 1;
   localparam int SW      = $clog2(PW + TABLE_BITS + 1);
   localparam int KW      = ((PW > TABLE_BITS) ? PW : TABLE_BITS) + 1;
   localparam int AW      = TABLE_BITS - 1;
   localparam int RW      = TABLE_BITS - 2;
   localparam int HALF    = 2 ** (TABLE_BITS - 3);
   localparam int QUARTER = 2 ** (TABLE_BITS - 2);

   logic [2*W-1:0] sq_col_full, sq_row_full;
   logic [PW-1:0]  sq_col_ff, sq_row_ff;
   zpg_pkg::raster_flags_type flags2_ff, flags3_ff;

   logic [AW-1:0]  rom_addr_ff, rom_addr_in;
   logic           negate_ff, negate_in;

   logic [SW-1:0]        lg_ext, up_shift, dn_shift;
   logic [PW-1:0]        sum, two_size_mask, phase;
   logic [PW+TABLE_BITS-1:0] p_up;
   logic [KW-1:0]        p_dn;
   logic [TABLE_BITS-1:0] k;
   logic [1:0]           quadrant;
   logic [RW-1:0]        r, n;
   logic                 fold, want_sin;

   assign sq_col_full = abs_col * abs_col;
   assign sq_row_full = abs_row * abs_row;

   // stage 2: squares, kept modulo 2^(W+1)
   always_ff @(posedge clock) begin
      if (load) begin
         sq_col_ff <= sq_col_full[PW-1:0];
         sq_row_ff <= sq_row_full[PW-1:0];
         flags2_ff <= flags_i;
      end
   end

   always_comb begin
      lg_ext        = SW'(lg);
      sum           = sq_col_ff + sq_row_ff;
      two_size_mask = PW'(((PW+1)'(1) << (lg_ext + SW'(1))) - (PW+1)'(1));
      phase         = sum & two_size_mask;

      up_shift = SW'(TABLE_BITS) - lg_ext - SW'(1);
      dn_shift = lg_ext - SW'(TABLE_BITS);
      p_up     = (PW+TABLE_BITS)'(phase) << up_shift;
      p_dn     = KW'(phase >> dn_shift) + KW'(1);

      // scale up when the table is finer than the phase, else round to nearest
      if ((lg_ext + SW'(1)) <= SW'(TABLE_BITS)) begin
         k = p_up[TABLE_BITS-1:0];
      end else begin
         k = p_dn[TABLE_BITS:1];
      end

      quadrant = k[TABLE_BITS-1:TABLE_BITS-2];
      r        = k[RW-1:0];
      fold     = r > RW'(HALF);
      n        = fold ? RW'((RW+1)'(QUARTER) - (RW+1)'(r)) : r;
      want_sin = quadrant[0] ^ fold;

      rom_addr_in = want_sin ? AW'(HALF + 1) + AW'(n) : AW'(n);
      negate_in   = quadrant[0] ^ quadrant[1];
   end

   // stage 3: ROM address
   always_ff @(posedge clock) begin
      if (load) begin
         rom_addr_ff <= rom_addr_in;
         negate_ff   <= negate_in;
         flags3_ff   <= flags2_ff;
      end
   end

   assign rom_addr = rom_addr_ff;
   assign negate   = negate_ff;
   assign flags_o  = flags3_ff;

endmodule

`default_nettype wire

// ===== design/zpg_cos_rom.sv =====
// ----------------------------------------------------------------------------
// zpg_cos_rom: octant cosine ROM
// Holds cos and sin over the first octant in units of 2*pi/2^TABLE_BITS,
// built at elaboration from a Q30 Taylor series, with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module zpg_cos_rom #(
   parameter int TABLE_BITS = 10
) (
   input  wire logic                    clock,
   input  wire logic                    rd_en,
   input  wire logic [TABLE_BITS-2:0]   rd_addr,
   output zpg_pkg::cos_word_type        rd_data
);

   localparam int HALF    = 2 ** (TABLE_BITS - 3);
   localparam int ENTRIES = 2 * HALF + 2;

   // Q30 series for an angle in [0, pi/4], clamped to [0, 1]
   function automatic longint unsigned series(input longint unsigned x, input bit want_sin);
      longint unsigned x2;
      longint unsigned term;
      longint unsigned prod;
      longint          sum;
      int              terms;
      x2    = (x * x + (zpg_pkg::Q30_ONE >> 1)) >> 30;
      term  = want_sin ? x : zpg_pkg::Q30_ONE;
      sum   = longint'(term);
      terms = want_sin ? 4 : 5;
      for (int k = 1; k <= terms; k++) begin
         prod = (term * x2) >> 30;
         if (want_sin) begin
            case (k)
               1:       term = prod / 6;
               2:       term = prod / 20;
               3:       term = prod / 42;
               default: term = prod / 72;
            endcase
         end else begin
            case (k)
               1:       term = prod / 2;
               2:       term = prod / 12;
               3:       term = prod / 30;
               4:       term = prod / 56;
               default: term = prod / 90;
            endcase
         end
         if ((k % 2) == 1) sum = sum - longint'(term);
         else              sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(zpg_pkg::Q30_ONE)) sum = longint'(zpg_pkg::Q30_ONE);
      return longint'(sum);
   endfunction

   // cos entries first (0..HALF), then sin entries (0..HALF)
   function automatic zpg_pkg::cos_word_type make_word(input int addr);
      zpg_pkg::cos_word_type word;
      bit                    want_sin;
      longint unsigned       idx;
      longint unsigned       x;
      longint unsigned       v;
      longint unsigned       mag;
      want_sin = addr > HALF;
      idx      = want_sin ? longint'(addr - HALF - 1) : longint'(addr);
      x        = (idx * zpg_pkg::HALF_PI_Q30 + longint'(HALF)) >> (TABLE_BITS - 2);
      v        = series(x, want_sin);
      mag      = (v * 32767 + (zpg_pkg::Q30_ONE >> 1)) >> 30;
      word.mag      = zpg_pkg::MAG_WIDTH'(mag);
      word.byte_pos = zpg_pkg::BYTE_WIDTH'((255 * (mag + 32767) + 32767) / 65534);
      word.byte_neg = zpg_pkg::BYTE_WIDTH'((255 * (32767 - mag) + 32767) / 65534);
      return word;
   endfunction

   zpg_pkg::cos_word_type rom_mem [ENTRIES];
   zpg_pkg::cos_word_type rd_data_ff;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
      localparam zpg_pkg::cos_word_type Word = make_word(g);
      assign rom_mem[g] = Word;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/zone_plate_pattern_generator.sv =====
// ----------------------------------------------------------------------------
// zone_plate_pattern_generator: square zone plate raster source
// Emits one pixel per request beat: cos of (i*i + j*j) over twice the side,
// as a signed value or a byte, with end of line and end of frame flags.
// ----------------------------------------------------------------------------
// The block delivers one pixel every clock while rsp_ready stays high; a
// pixel passes through the raster, square, phase/address, cosine ROM read and
// output registers on its way to the response side, the first of them loaded
// by the request beat itself. The cosine ROM holds 2^(TABLE_BITS-2)+2 words
// and is read once per pixel, which sets the rate at one beat per clock. A
// stalled response stalls the whole pipe. Side and byte mode come from two
// registers that the user writes through the csr_ port only while the block is
// idle (not enforced); the ROM is constant and needs no fill after reset.
`default_nettype none

module zone_plate_pattern_generator #(
   parameter int MAX_LOG2_SIZE = 12,
   parameter int TABLE_BITS    = 10
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_ready,
   input  wire logic                                      req_restart,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_ready,
   output logic signed [zpg_pkg::PIXEL_WIDTH-1:0]         rsp_pixel_value,
   output logic                                           rsp_end_of_line,
   output logic                                           rsp_end_of_frame,
   input  wire logic                                      csr_valid,
   output logic                                           csr_ready,
   input  wire logic [zpg_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  wire logic [zpg_pkg::CSR_DATA_WIDTH-1:0]        csr_wdata
);

   localparam int LG_W = $clog2(MAX_LOG2_SIZE+1);

   logic [zpg_pkg::CSR_DATA_WIDTH-1:0] log2_size_ff;
   logic                               byte_output_ff;
   logic [LG_W-1:0]                    lg_eff;

   logic        advance, accept;
   logic [3:0]  pipe_valid_ff;
   logic        rsp_valid_ff;

   logic [MAX_LOG2_SIZE-1:0] abs_col, abs_row;
   zpg_pkg::raster_flags_type flags1, flags3, flags4_ff, flags_out_ff;
   logic [TABLE_BITS-2:0]    rom_addr;
   logic                     negate3, negate4_ff;
   zpg_pkg::cos_word_type    rom_word;

   logic signed [zpg_pkg::PIXEL_WIDTH-1:0] pixel_ff, pixel_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_size_ff   <= zpg_pkg::LOG2_SIZE_RESET;
         byte_output_ff <= zpg_pkg::BYTE_OUTPUT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            zpg_pkg::CSR_LOG2_SIZE:   log2_size_ff   <= csr_wdata;
            zpg_pkg::CSR_BYTE_OUTPUT: byte_output_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (log2_size_ff == '0) begin
         lg_eff = LG_W'(1);
      end else if (int'(log2_size_ff) > MAX_LOG2_SIZE) begin
         lg_eff = LG_W'(MAX_LOG2_SIZE);
      end else begin
         lg_eff = LG_W'(log2_size_ff);
      end
   end

   // the pipe moves whenever the output register is free or being drained
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         pipe_valid_ff <= {pipe_valid_ff[2:0], accept};
         rsp_valid_ff  <= pipe_valid_ff[3];
      end
   end

   zpg_raster #(
      .MAX_LOG2_SIZE (MAX_LOG2_SIZE)
   ) u_raster (
      .clock   (clock),
      .reset   (reset),
      .load    (advance),
      .accept  (accept),
      .restart (req_restart),
      .lg      (lg_eff),
      .abs_col (abs_col),
      .abs_row (abs_row),
      .flags   (flags1)
   );

   zpg_phase #(
      .MAX_LOG2_SIZE (MAX_LOG2_SIZE),
      .TABLE_BITS    (TABLE_BITS)
   ) u_phase (
      .clock    (clock),
      .load     (advance),
      .abs_col  (abs_col),
      .abs_row  (abs_row),
      .lg       (lg_eff),
      .flags_i  (flags1),
      .rom_addr (rom_addr),
      .negate   (negate3),
      .flags_o  (flags3)
   );

   zpg_cos_rom #(
      .TABLE_BITS (TABLE_BITS)
   ) u_cos_rom (
      .clock   (clock),
      .rd_en   (advance),
      .rd_addr (rom_addr),
      .rd_data (rom_word)
   );

   // carry sign and flags alongside the ROM read
   always_ff @(posedge clock) begin
      if (advance) begin
         negate4_ff <= negate3;
         flags4_ff  <= flags3;
      end
   end

   always_comb begin
      if (byte_output_ff) begin
         pixel_in = {8'd0, (negate4_ff ? rom_word.byte_neg : rom_word.byte_pos)};
      end else if (negate4_ff) begin
         pixel_in = 16'sd0 - signed'({1'b0, rom_word.mag});
      end else begin
         pixel_in = signed'({1'b0, rom_word.mag});
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff     <= pixel_in;
         flags_out_ff <= flags4_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_value  = pixel_ff;
   assign rsp_end_of_line  = flags_out_ff.end_of_line;
   assign rsp_end_of_frame = flags_out_ff.end_of_frame;

endmodule

`default_nettype wire

// ===== design/zpg_checker.sv =====
// ----------------------------------------------------------------------------
// zpg_checker: port checks of the zone plate generator
// Watches the request and response ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module zpg_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_ready,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_ready,
   input wire logic signed [zpg_pkg::PIXEL_WIDTH-1:0] rsp_pixel_value,
   input wire logic                                   rsp_end_of_line,
   input wire logic                                   rsp_end_of_frame
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_value)
         && $stable(rsp_end_of_line) && $stable(rsp_end_of_frame))
      else $error("response beat changed while stalled");

   // the frame ends only on the last pixel of a row
   a_eof_on_eol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> rsp_end_of_line)
      else $error("end of frame without end of line");

   // input is throttled only by a waiting response beat
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // the cosine never reaches the most negative code
   a_pixel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_value != 16'sh8000)
      else $error("pixel out of range");

endmodule

bind zone_plate_pattern_generator zpg_checker u_zpg_checker (.*);

`default_nettype wire
